// ----- src/adi_pkg.sv -----
// ----------------------------------------------------------------------------
// adi_pkg - shared types and constants for the decimal string parser
// Character codes, parser phases and the structs passed between modules.
// ----------------------------------------------------------------------------
package adi_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIGIT_W = 4;
  // magnitude * 10 + digit fits in this many bits
  localparam int unsigned ACC_W   = MAG_W + 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_WAIT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic               is_nul;
    logic               is_ws;
    logic               is_plus;
    logic               is_minus;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

  typedef struct packed {
    phase_t           phase;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } parse_state_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } parse_result_t;

endpackage

// ----- src/ascii_decimal_to_int32_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_decimal_to_int32_unit - streaming ASCII decimal to int32 parser
// Registers each byte, runs one parser step and registers the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_ch carries one character per beat;
//   a NUL byte ends each string. Leading whitespace and one sign are taken,
//   then digits up to the first non-digit, which produces one result beat
//   on out_valid/out_ready with out_ok and out_value (zero when out_ok is 0).
//   Missing digits and magnitudes above 2147483647 give out_ok = 0.
//   Bytes after a decision are dropped up to and including the next NUL.
//   Path: a deciding byte reaches out_valid through two register stages
//   (input byte, then result). Throughput: one byte per cycle while the
//   result channel does not stall; each step is a constant multiply-add
//   and compare on the 31-bit magnitude between the two registers.
//   Stall: when a result waits and out_ready is low, the held byte does not
//   advance and in_ready drops once the input register is full; no beat is
//   lost. Reset (rst_n low, synchronous) empties both registers and returns
//   the parser to skipping whitespace.
// ----------------------------------------------------------------------------
module ascii_decimal_to_int32_unit
  import adi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAR_W-1:0]         in_ch,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic signed [VALUE_W-1:0] out_value
);

  logic              stage_v_r;
  logic [CHAR_W-1:0] stage_ch_r;
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  logic              out_v_r;
  parse_result_t     res_r;
  parse_result_t     res_nxt;
  char_class_t       cls;
  logic              emit;
  logic              advance;

  // the held byte steps only when the result register can take a beat
  assign advance  = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || advance;

  adi_classify u_classify (
    .ch  (stage_ch_r),
    .cls (cls)
  );

  adi_step u_step (
    .cur  (state_r),
    .cls  (cls),
    .nxt  (state_nxt),
    .emit (emit),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_ch_r <= in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_SKIP;
      state_r.negative  <= 1'b0;
      state_r.magnitude <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= emit;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_ok    = res_r.ok;
  assign out_value = res_r.value;

endmodule

// ----- src/adi_classify.sv -----
// ----------------------------------------------------------------------------
// adi_classify - character classifier
// Sorts one byte into NUL, whitespace, sign or digit and extracts the digit.
// ----------------------------------------------------------------------------
module adi_classify
  import adi_pkg::*;
(
  input  logic [CHAR_W-1:0] ch,
  output char_class_t       cls
);

  always_comb begin
    cls.is_nul   = (ch == CH_NUL);
    cls.is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                   (ch == CH_CR) || (ch == CH_VT) || (ch == CH_FF);
    cls.is_plus  = (ch == CH_PLUS);
    cls.is_minus = (ch == CH_MINUS);
    cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    // low nibble of '0'..'9' is the digit value
    cls.digit    = ch[DIGIT_W-1:0];
  end

endmodule

// ----- src/adi_step.sv -----
// ----------------------------------------------------------------------------
// adi_step - parser step logic
// Computes the next parser state and the optional result for one byte.
// ----------------------------------------------------------------------------
module adi_step
  import adi_pkg::*;
(
  input  parse_state_t  cur,
  input  char_class_t   cls,
  output parse_state_t  nxt,
  output logic          emit,
  output parse_result_t res
);

  logic [ACC_W-1:0] acc;
  logic             overflow;
  logic             decide;
  logic             good;

  // magnitude * 10 + digit as two shifted adds
  assign acc = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0}
             + {{(ACC_W-DIGIT_W){1'b0}}, cls.digit};
  assign overflow = (acc[ACC_W-1:MAG_W] != '0);

  // decision: a result goes out on this byte
  always_comb begin
    decide = 1'b0;
    good   = 1'b0;
    unique case (cur.phase)
      PH_SKIP: begin
        decide = !cls.is_ws && !cls.is_plus && !cls.is_minus && !cls.is_digit;
      end
      PH_SIGN: begin
        decide = !cls.is_digit;
      end
      PH_DIGITS: begin
        decide = !cls.is_digit || overflow;
        good   = !cls.is_digit;
      end
      PH_WAIT: begin
        decide = 1'b0;
      end
      default: begin
        decide = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    nxt = cur;
    if (decide) begin
      if (cls.is_nul) begin
        nxt.phase     = PH_SKIP;
        nxt.negative  = 1'b0;
        nxt.magnitude = '0;
      end else begin
        nxt.phase = PH_WAIT;
      end
    end else begin
      unique case (cur.phase)
        PH_SKIP: begin
          if (cls.is_plus || cls.is_minus) begin
            nxt.negative = cls.is_minus;
            nxt.phase    = PH_SIGN;
          end else if (cls.is_digit) begin
            nxt.magnitude = {{(MAG_W-DIGIT_W){1'b0}}, cls.digit};
            nxt.phase     = PH_DIGITS;
          end
        end
        PH_SIGN: begin
          nxt.magnitude = {{(MAG_W-DIGIT_W){1'b0}}, cls.digit};
          nxt.phase     = PH_DIGITS;
        end
        PH_DIGITS: begin
          nxt.magnitude = acc[MAG_W-1:0];
        end
        PH_WAIT: begin
          if (cls.is_nul) begin
            nxt.phase     = PH_SKIP;
            nxt.negative  = 1'b0;
            nxt.magnitude = '0;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    emit      = decide;
    res.ok    = good;
    res.value = '0;
    if (good) begin
      res.value = cur.negative ? (VALUE_W'(0) - {1'b0, cur.magnitude})
                               : {1'b0, cur.magnitude};
    end
  end

endmodule

// ----- src/adi_checker.sv -----
// ----------------------------------------------------------------------------
// adi_checker - port-level checks for the decimal string parser
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module adi_checker
  import adi_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_ok,
  input logic signed [VALUE_W-1:0] out_value
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_value))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0)
    else $error("failed parse carries a nonzero value");

  // the most negative int32 is never a good result
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_value != {1'b1, {(VALUE_W-1){1'b0}}})
    else $error("good result holds the most negative value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("channels not empty after reset");

endmodule

bind ascii_decimal_to_int32_unit adi_checker u_adi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_ok    (out_ok),
  .out_value (out_value)
);
